FILE: src/tbw_pkg.sv
`timescale 1ns / 1ps
package tbw_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int WEIGHT_WIDTH = 48;

  // Widths of the intermediate values.
  localparam int CROSS_WIDTH = 33;                      // |cross| <= 2^31
  localparam int MAG_WIDTH   = 32;                      // magnitude of a cross product
  localparam int QUO_WIDTH   = MAG_WIDTH + FRAC_BITS;   // quotient bits
  localparam int SUM_WIDTH   = QUO_WIDTH + 3;           // room for 2^F - v - w
  localparam int DIV_STEPS   = QUO_WIDTH;               // one quotient bit per stage

  typedef struct packed {
    logic signed [15:0] corner_a_x;
    logic signed [15:0] corner_a_y;
    logic signed [15:0] corner_b_x;
    logic signed [15:0] corner_b_y;
    logic signed [15:0] corner_c_x;
    logic signed [15:0] corner_c_y;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
  } tbw_in_t;

  typedef struct packed {
    logic signed [WEIGHT_WIDTH-1:0] weight_u;
    logic signed [WEIGHT_WIDTH-1:0] weight_v;
    logic signed [WEIGHT_WIDTH-1:0] weight_w;
    logic                           degenerate;
    logic                           saturated;
  } tbw_out_t;

  // Classified work item handed from the front end to the divider pipeline.
  typedef struct packed {
    logic [MAG_WIDTH-1:0] num_v_mag;
    logic [MAG_WIDTH-1:0] num_w_mag;
    logic [MAG_WIDTH-1:0] den_mag;
    logic                 neg_v;
    logic                 neg_w;
    logic                 degenerate;
  } tbw_work_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

endpackage

FILE: src/triangle_barycentric_weights_unit.sv
`timescale 1ns / 1ps
// Barycentric weights of a query point in a 2D triangle. One beat in carries the
// three corners and the point; one beat out carries u, v, w in signed fixed point
// with FRAC_BITS fraction bits, plus degenerate and saturated flags. The unit
// accepts one beat per cycle unless a full work queue holds up the front end. The
// path runs through two front stages (edge vectors, cross products), the work
// queue, one input register in front of the divider, one stage per quotient bit
// in the pipelined divider (48 at default settings), and one sign, sum and clamp
// stage. The work queue, four items deep, lets the front keep taking beats while
// the output is stalled.
module triangle_barycentric_weights_unit import tbw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tbw_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tbw_out_t out_data_o
);

  logic      f_valid, f_ready, b_valid, b_ready;
  tbw_work_t f_work, b_work;

  tbw_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .work_valid_o(f_valid), .work_ready_i(f_ready), .work_o(f_work)
  );

  tbw_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(f_work),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_data_o(b_work)
  );

  tbw_back u_back (
    .clk_i, .rst_ni,
    .work_valid_i(b_valid), .work_ready_o(b_ready), .work_i(b_work),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

FILE: src/tbw_front.sv
`timescale 1ns / 1ps
module tbw_front import tbw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tbw_in_t   in_data_i,
  output logic      work_valid_o,
  input  logic      work_ready_i,
  output tbw_work_t work_o
);

  // Stage 1 registers the wrapped edge vectors, stage 2 the cross products.
  logic              s1_valid_q, s2_valid_q;
  logic signed [15:0] e0x_q, e0y_q, e1x_q, e1y_q, qx_q, qy_q;
  logic signed [CROSS_WIDTH-1:0] area_q, nv_q, nw_q;
  logic signed [31:0] p_a0, p_a1, p_v0, p_v1, p_w0, p_w1;
  logic signed [CROSS_WIDTH-1:0] area_d, nv_d, nw_d;
  logic s1_adv, s2_adv;

  assign s2_adv     = !s2_valid_q || work_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;

  assign p_a0 = e0x_q * e1y_q;
  assign p_a1 = e0y_q * e1x_q;
  assign p_v0 = qx_q * e1y_q;
  assign p_v1 = qy_q * e1x_q;
  assign p_w0 = e0x_q * qy_q;
  assign p_w1 = e0y_q * qx_q;
  assign area_d = CROSS_WIDTH'(p_a0) - CROSS_WIDTH'(p_a1);
  assign nv_d   = CROSS_WIDTH'(p_v0) - CROSS_WIDTH'(p_v1);
  assign nw_d   = CROSS_WIDTH'(p_w0) - CROSS_WIDTH'(p_w1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      e0x_q <= in_data_i.corner_b_x - in_data_i.corner_a_x;
      e0y_q <= in_data_i.corner_b_y - in_data_i.corner_a_y;
      e1x_q <= in_data_i.corner_c_x - in_data_i.corner_a_x;
      e1y_q <= in_data_i.corner_c_y - in_data_i.corner_a_y;
      qx_q  <= in_data_i.query_x - in_data_i.corner_a_x;
      qy_q  <= in_data_i.query_y - in_data_i.corner_a_y;
    end
    if (s2_adv && s1_valid_q) begin
      area_q <= area_d;
      nv_q   <= nv_d;
      nw_q   <= nw_d;
    end
  end

  function automatic logic [MAG_WIDTH-1:0] mag(input logic signed [CROSS_WIDTH-1:0] x);
    logic [CROSS_WIDTH-1:0] a;
    a = x[CROSS_WIDTH-1] ? CROSS_WIDTH'(-x) : CROSS_WIDTH'(x);
    return a[MAG_WIDTH-1:0];
  endfunction

  assign work_valid_o      = s2_valid_q;
  assign work_o.num_v_mag  = mag(nv_q);
  assign work_o.num_w_mag  = mag(nw_q);
  assign work_o.den_mag    = mag(area_q);
  assign work_o.neg_v      = nv_q[CROSS_WIDTH-1] ^ area_q[CROSS_WIDTH-1];
  assign work_o.neg_w      = nw_q[CROSS_WIDTH-1] ^ area_q[CROSS_WIDTH-1];
  assign work_o.degenerate = (area_q == '0);

endmodule

FILE: src/tbw_queue.sv
`timescale 1ns / 1ps
module tbw_queue import tbw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  tbw_work_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output tbw_work_t pop_data_o
);

  tbw_work_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_q, rd_q;
  logic [QPTR_WIDTH:0]   cnt_q;
  logic                  push, pop;

  assign push_ready_o = (cnt_q != (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_WIDTH+1)'(push) - (QPTR_WIDTH+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

FILE: src/tbw_back.sv
`timescale 1ns / 1ps
module tbw_back import tbw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      work_valid_i,
  output logic      work_ready_o,
  input  tbw_work_t work_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tbw_out_t  out_data_o
);

  // Restoring division, one quotient bit per stage, both quotients in parallel.
  typedef struct packed {
    logic                 valid;
    logic [QUO_WIDTH-1:0] nv;    // numerator bits, shifted out msb first
    logic [QUO_WIDTH-1:0] nw;
    logic [MAG_WIDTH:0]   rv;    // partial remainders
    logic [MAG_WIDTH:0]   rw;
    logic [QUO_WIDTH-1:0] qv;
    logic [QUO_WIDTH-1:0] qw;
    logic [MAG_WIDTH-1:0] den;
    logic                 neg_v;
    logic                 neg_w;
    logic                 degenerate;
  } div_t;

  div_t     st_q [DIV_STEPS+1];
  div_t     st_d [DIV_STEPS+1];
  logic     adv;
  logic     fin_valid_q;
  tbw_out_t fin_q, fin_d;

  assign adv          = !fin_valid_q || out_ready_i;
  assign work_ready_o = adv;

  always_comb begin
    st_d[0]            = '0;
    st_d[0].valid      = work_valid_i;
    st_d[0].nv         = {work_i.num_v_mag, FRAC_BITS'(0)};
    st_d[0].nw         = {work_i.num_w_mag, FRAC_BITS'(0)};
    st_d[0].den        = work_i.degenerate ? MAG_WIDTH'(1) : work_i.den_mag;
    st_d[0].neg_v      = work_i.neg_v;
    st_d[0].neg_w      = work_i.neg_w;
    st_d[0].degenerate = work_i.degenerate;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [MAG_WIDTH:0] tv, tw;
    always_comb begin
      st_d[k+1] = st_q[k];
      tv = {st_q[k].rv[MAG_WIDTH-1:0], st_q[k].nv[QUO_WIDTH-1]};
      tw = {st_q[k].rw[MAG_WIDTH-1:0], st_q[k].nw[QUO_WIDTH-1]};
      st_d[k+1].nv = {st_q[k].nv[QUO_WIDTH-2:0], 1'b0};
      st_d[k+1].nw = {st_q[k].nw[QUO_WIDTH-2:0], 1'b0};
      if (tv >= {1'b0, st_q[k].den}) begin
        st_d[k+1].rv = tv - {1'b0, st_q[k].den};
        st_d[k+1].qv = {st_q[k].qv[QUO_WIDTH-2:0], 1'b1};
      end else begin
        st_d[k+1].rv = tv;
        st_d[k+1].qv = {st_q[k].qv[QUO_WIDTH-2:0], 1'b0};
      end
      if (tw >= {1'b0, st_q[k].den}) begin
        st_d[k+1].rw = tw - {1'b0, st_q[k].den};
        st_d[k+1].qw = {st_q[k].qw[QUO_WIDTH-2:0], 1'b1};
      end else begin
        st_d[k+1].rw = tw;
        st_d[k+1].qw = {st_q[k].qw[QUO_WIDTH-2:0], 1'b0};
      end
    end
  end

  // Sign, sum and clamp.
  function automatic logic signed [WEIGHT_WIDTH-1:0] clamp(
    input logic signed [SUM_WIDTH-1:0] x, output logic sat);
    logic signed [SUM_WIDTH-1:0] hi, lo;
    hi  = SUM_WIDTH'({1'b0, {(WEIGHT_WIDTH-1){1'b1}}});
    lo  = -hi - SUM_WIDTH'(1);
    sat = 1'b0;
    if (SUM_WIDTH <= WEIGHT_WIDTH) return WEIGHT_WIDTH'(x);
    if (x > hi) begin
      sat = 1'b1;
      return WEIGHT_WIDTH'(hi);
    end
    if (x < lo) begin
      sat = 1'b1;
      return WEIGHT_WIDTH'(lo);
    end
    return WEIGHT_WIDTH'(x);
  endfunction

  always_comb begin
    logic signed [SUM_WIDTH-1:0] v, w, u;
    logic su, sv, sw;
    v = st_q[DIV_STEPS].neg_v ? -SUM_WIDTH'(st_q[DIV_STEPS].qv) : SUM_WIDTH'(st_q[DIV_STEPS].qv);
    w = st_q[DIV_STEPS].neg_w ? -SUM_WIDTH'(st_q[DIV_STEPS].qw) : SUM_WIDTH'(st_q[DIV_STEPS].qw);
    u = (SUM_WIDTH'(1) <<< FRAC_BITS) - v - w;
    fin_d.weight_u   = clamp(u, su);
    fin_d.weight_v   = clamp(v, sv);
    fin_d.weight_w   = clamp(w, sw);
    fin_d.saturated  = su | sv | sw;
    fin_d.degenerate = 1'b0;
    if (st_q[DIV_STEPS].degenerate) begin
      fin_d = '0;
      fin_d.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) st_q[k] <= '0;
      fin_valid_q <= 1'b0;
      fin_q       <= '0;
    end else if (adv) begin
      for (int k = 0; k <= DIV_STEPS; k++) st_q[k] <= st_d[k];
      fin_valid_q <= st_q[DIV_STEPS].valid;
      fin_q       <= fin_d;
    end
  end

  assign out_valid_o = fin_valid_q;
  assign out_data_o  = fin_q;

endmodule

FILE: src/tbw_checker.sv
`timescale 1ns / 1ps
module tbw_checker import tbw_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tbw_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.weight_u == '0 && out_data_o.weight_v == '0 &&
      out_data_o.weight_w == '0 && !out_data_o.saturated)
    else $error("degenerate beat carries nonzero fields");

  a_no_early_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output is empty");

endmodule

bind triangle_barycentric_weights_unit tbw_checker u_tbw_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

FILE: sim/triangle_barycentric_weights_unit_tb.sv
`timescale 1ns / 1ps
module triangle_barycentric_weights_unit_tb;
  import tbw_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  tbw_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  tbw_out_t out_data_o;

  triangle_barycentric_weights_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Triangles waiting to be sent, and weights the block still owes us.
  tbw_in_t  tri_pending[$];
  tbw_out_t weights_owed[$];
  int       n_errors = 0;
  bit       stim_done = 0;
  bit       drain_hold = 0;

  // Exact signed ratio num * 2^FRAC_BITS / den, rounded toward zero.
  function automatic longint ratio_trunc(longint num, longint den);
    longint mn, md, q;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    q = (mn <<< FRAC_BITS) / md;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // Clamps one weight to the signed output width and notes any clamp.
  function automatic logic [WEIGHT_WIDTH-1:0] clamp_weight(longint x, inout bit sat);
    longint hi, lo;
    hi = (longint'(1) <<< (WEIGHT_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      x = hi;
      sat = 1;
    end
    if (x < lo) begin
      x = lo;
      sat = 1;
    end
    return x[WEIGHT_WIDTH-1:0];
  endfunction

  // Predicts the barycentric weights of one beat.
  function automatic tbw_out_t bary_weights(tbw_in_t t);
    tbw_out_t r;
    logic signed [15:0] e0x, e0y, e1x, e1y, qx, qy;
    longint area, v, w, u;
    bit sat;
    r = '0;
    sat = 0;
    // Edge differences wrap to 16 bits.
    e0x = t.corner_b_x - t.corner_a_x;
    e0y = t.corner_b_y - t.corner_a_y;
    e1x = t.corner_c_x - t.corner_a_x;
    e1y = t.corner_c_y - t.corner_a_y;
    qx  = t.query_x - t.corner_a_x;
    qy  = t.query_y - t.corner_a_y;
    area = longint'(e0x) * e1y - longint'(e0y) * e1x;
    if (area == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    v = ratio_trunc(longint'(qx) * e1y - longint'(qy) * e1x, area);
    w = ratio_trunc(longint'(e0x) * qy - longint'(e0y) * qx, area);
    u = (longint'(1) <<< FRAC_BITS) - v - w;
    r.weight_u = clamp_weight(u, sat);
    r.weight_v = clamp_weight(v, sat);
    r.weight_w = clamp_weight(w, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [15:0] coord_rand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed triangles of modest size near a random origin, with a
  // share of fully random corners, degenerate lines and extremes.
  function automatic tbw_in_t tri_rand();
    tbw_in_t t;
    logic [15:0] ox, oy;
    int span;
    t = '0;
    case ($urandom_range(0, 9))
      0, 1: begin
        t.corner_a_x = coord_rand(); t.corner_a_y = coord_rand();
        t.corner_b_x = coord_rand(); t.corner_b_y = coord_rand();
        t.corner_c_x = coord_rand(); t.corner_c_y = coord_rand();
        t.query_x = coord_rand();    t.query_y = coord_rand();
      end
      2: begin
        // Collinear corners.
        ox = 16'($urandom); oy = 16'($urandom);
        span = $urandom_range(1, 300);
        t.corner_a_x = ox; t.corner_a_y = oy;
        t.corner_b_x = ox + 16'(span); t.corner_b_y = oy + 16'(2 * span);
        t.corner_c_x = ox - 16'(3 * span); t.corner_c_y = oy - 16'(6 * span);
        t.query_x = 16'($urandom); t.query_y = 16'($urandom);
      end
      default: begin
        ox = 16'($urandom); oy = 16'($urandom);
        span = 1 << $urandom_range(1, 14);
        t.corner_a_x = ox; t.corner_a_y = oy;
        t.corner_b_x = ox + 16'($urandom_range(0, span));
        t.corner_b_y = oy + 16'($urandom_range(0, span));
        t.corner_c_x = ox + 16'($urandom_range(0, span));
        t.corner_c_y = oy + 16'($urandom_range(0, span));
        t.query_x = ox + 16'($urandom_range(0, 2 * span)) - 16'(span / 2);
        t.query_y = oy + 16'($urandom_range(0, 2 * span)) - 16'(span / 2);
      end
    endcase
    return t;
  endfunction

  function automatic tbw_in_t tri_make(int ax, int ay, int bx, int by,
                                       int cx, int cy, int px, int py);
    tbw_in_t t;
    t.corner_a_x = 16'(ax); t.corner_a_y = 16'(ay);
    t.corner_b_x = 16'(bx); t.corner_b_y = 16'(by);
    t.corner_c_x = 16'(cx); t.corner_c_y = 16'(cy);
    t.query_x = 16'(px);    t.query_y = 16'(py);
    return t;
  endfunction

  // Driver: one beat per queued triangle, with a random gap before each.
  int send_gap = 0;
  int n_sent = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        weights_owed.push_back(bary_weights(in_data_i));
        n_sent++;
        send_gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!in_valid_i || in_ready_o) begin
        // Pause once midway until every owed result has come back.
        if (n_sent == 700 && !drain_hold) drain_hold = 1;
        if (drain_hold && weights_owed.size() == 0) drain_hold = 0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (tri_pending.size() > 0 && !(drain_hold && n_sent == 700)) begin
          in_valid_i <= 1'b1;
          in_data_i <= tri_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          if (tri_pending.size() == 0) stim_done = 1;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  int stall = 0;
  tbw_out_t exp_w;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (weights_owed.size() == 0) begin
          $error("unexpected result beat %p", out_data_o);
          n_errors++;
        end else begin
          exp_w = weights_owed.pop_front();
          if (out_data_o.weight_u !== exp_w.weight_u) begin
            $error("weight_u expected %0d got %0d", exp_w.weight_u, out_data_o.weight_u);
            n_errors++;
          end
          if (out_data_o.weight_v !== exp_w.weight_v) begin
            $error("weight_v expected %0d got %0d", exp_w.weight_v, out_data_o.weight_v);
            n_errors++;
          end
          if (out_data_o.weight_w !== exp_w.weight_w) begin
            $error("weight_w expected %0d got %0d", exp_w.weight_w, out_data_o.weight_w);
            n_errors++;
          end
          if (out_data_o.degenerate !== exp_w.degenerate) begin
            $error("degenerate expected %0b got %0b", exp_w.degenerate,
                   out_data_o.degenerate);
            n_errors++;
          end
          if (out_data_o.saturated !== exp_w.saturated) begin
            $error("saturated expected %0b got %0b", exp_w.saturated,
                   out_data_o.saturated);
            n_errors++;
          end
        end
        stall = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    // Directed beats: extremes, degenerate shapes and wrapping edges.
    tri_pending.push_back(tri_make(0, 0, 0, 0, 0, 0, 0, 0));
    tri_pending.push_back(tri_make(0, 0, 100, 0, 0, 100, 25, 25));
    tri_pending.push_back(tri_make(0, 0, 100, 0, 0, 100, 0, 0));
    tri_pending.push_back(tri_make(0, 0, 100, 0, 0, 100, 100, 0));
    tri_pending.push_back(tri_make(0, 0, 100, 0, 0, 100, -500, 700));
    tri_pending.push_back(tri_make(0, 0, 3, 0, 0, 3, 1, 1));
    tri_pending.push_back(tri_make(0, 0, 10, 10, 20, 20, 5, 7));
    tri_pending.push_back(tri_make(5, 5, 5, 5, 9, 1, 0, 0));
    tri_pending.push_back(tri_make(-32768, -32768, 32767, -32768, -32768, 32767,
                                   0, 0));
    tri_pending.push_back(tri_make(32767, 32767, -32768, 32767, 32767, -32768,
                                   -32768, -32768));
    tri_pending.push_back(tri_make(0, 0, 1, 0, 0, 1, -32768, 32767));
    tri_pending.push_back(tri_make(0, 0, 1, 0, 0, 1, 32767, 32767));
    tri_pending.push_back(tri_make(0, 0, 1, 0, 0, 1, -32768, -32768));
    tri_pending.push_back(tri_make(0, 0, 1, 1, 1, 0, 32767, -32768));
    tri_pending.push_back(tri_make(0, 0, 32767, 0, 0, 32767, 1, 1));
    tri_pending.push_back(tri_make(-32768, 0, -32768, -32768, 0, 0, 32767, 32767));
    tri_pending.push_back(tri_make(-1, -1, -1, -1, -1, -1, -1, -1));
    tri_pending.push_back(tri_make(-32768, -32768, -32768, -32768, -32768, -32768,
                                   -32768, -32768));
    tri_pending.push_back(tri_make(32767, 32767, 32767, 32767, 32767, 32767,
                                   32767, 32767));
    tri_pending.push_back(tri_make(0, 0, -32768, 0, 0, -32768, 0, 0));
    tri_pending.push_back(tri_make(0, 0, 2, 1, 1, 2, -32768, 32767));
    for (int i = 0; i < 1400; i++) tri_pending.push_back(tri_rand());
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && weights_owed.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
